@@ rtl/bpa_pkg.sv @@
// bpa_pkg: constants, codes and controller/datapath interface types for the
// bitmap page allocator. No dependencies.
`default_nettype none
package bpa_pkg;

   localparam int MAX_PAGES  = 4096;
   localparam int PAGE_SHIFT = 12;
   localparam int WORD_BITS  = 64;
   localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
   localparam int PAGE_W     = $clog2(MAX_PAGES) + 1;
   localparam int PIDX_W     = $clog2(MAX_PAGES);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WIDX_W     = $clog2(MAP_WORDS);
   localparam int ADDR_W     = 24;
   localparam int COUNT_W    = 25;

   typedef enum logic [1:0] {
      FN_ALLOC = 2'd0,
      FN_FREE  = 2'd1,
      FN_LOCK  = 2'd2,
      FN_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FETCH,
      ST_WALK,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic load;
      logic fetch;
      logic step;
      logic write;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic fin;
      logic leave;
      logic dirty;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/bpa_ctrl.sv @@
// bpa_ctrl: sequencer for the page walk (load word, walk pages, write back,
// respond). Depends on bpa_pkg.
`default_nettype none
module bpa_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  bpa_pkg::status_type status,
   output bpa_pkg::cmd_type    cmd
);
   import bpa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = status.fin ? ST_RESP : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (status.leave) state_in = status.dirty ? ST_WRITE : ST_LOAD;
         end
         ST_WRITE: begin
            state_in = ST_LOAD;
         end
         ST_RESP: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_LOAD: begin
            cmd.load = !status.fin;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
         end
         ST_RESP: begin
            cmd.respond = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/bpa_datapath.sv @@
// bpa_datapath: occupancy memory, word buffer, page walker, hint, page total
// and result register. Depends on bpa_pkg.
`default_nettype none
module bpa_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [1:0]                   req_func,
   input  wire  [bpa_pkg::ADDR_W-1:0]   req_address,
   input  wire  [bpa_pkg::COUNT_W-1:0]  req_byte_count,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_ok,
   output logic [bpa_pkg::ADDR_W-1:0]   rsp_run_address,
   input  wire                          csr_wr_en,
   input  wire  [12:0]                  csr_wr_data,
   input  bpa_pkg::cmd_type             cmd,
   output bpa_pkg::status_type          status
);
   import bpa_pkg::*;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_ff;
   logic                 rdv_ff;
   logic [MAP_WORDS-1:0] valid_ff;

   logic [12:0]          total_ff;
   logic [PAGE_W-1:0]    hint_ff, hint_in;
   logic [PAGE_W-1:0]    cur_ff, cur_in;
   logic [PAGE_W-1:0]    run_ff, run_in;
   logic [PAGE_W-1:0]    cnt_ff, cnt_in;
   logic [PAGE_W-1:0]    rem_ff, rem_in;
   logic                 scan_ff, scan_in;
   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 ok_ff, ok_in;
   logic [PIDX_W-1:0]    start_ff, start_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [WIDX_W-1:0]    widx_ff;
   logic                 dirty_ff, dirty_in;
   logic                 rsp_valid_ff;
   logic                 rsp_ok_ff;
   logic [PIDX_W-1:0]    rsp_page_ff;

   logic [PAGE_W-1:0]    limit;
   logic [PAGE_W-1:0]    pages;
   logic [PAGE_W-1:0]    first;
   logic [COUNT_W:0]     round_sum;
   logic [PAGE_W-1:0]    run_n;
   logic [PAGE_W-1:0]    hit_start;
   logic                 page_bit;
   logic                 word_end;
   logic                 modify;
   logic                 leave;

   assign limit     = (total_ff > 13'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : PAGE_W'(total_ff);
   assign round_sum = {1'b0, req_byte_count} + (COUNT_W+1)'((1 << PAGE_SHIFT) - 1);
   // a count past the register width saturates; no run is ever that long
   assign pages     = round_sum[COUNT_W] ? {PAGE_W{1'b1}} : round_sum[COUNT_W-1:PAGE_SHIFT];
   assign first     = PAGE_W'(req_address >> PAGE_SHIFT);
   assign page_bit  = word_ff[cur_ff[BIT_W-1:0]];
   assign word_end  = &cur_ff[BIT_W-1:0];
   assign run_n     = page_bit ? '0 : run_ff + 1'b1;
   assign hit_start = cur_ff + 1'b1 - cnt_ff;

   always_comb begin
      hint_in  = hint_ff;
      cur_in   = cur_ff;
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      scan_in  = scan_ff;
      busy_in  = busy_ff;
      fin_in   = fin_ff;
      ok_in    = ok_ff;
      start_in = start_ff;
      word_in  = word_ff;
      dirty_in = dirty_ff;
      modify   = 1'b0;
      leave    = 1'b0;
      if (cmd.start) begin
         cur_in   = '0;
         run_in   = '0;
         cnt_in   = pages;
         rem_in   = pages;
         start_in = '0;
         busy_in  = 1'b1;
         scan_in  = 1'b0;
         dirty_in = 1'b0;
         unique case (func_type'(req_func))
            FN_ALLOC: begin
               scan_in = 1'b1;
               cur_in  = hint_ff;
               ok_in   = 1'b0;
               fin_in  = (pages == '0) || (hint_ff >= limit);
               if (fin_in) hint_in = '0;
            end
            FN_FREE, FN_LOCK: begin
               busy_in = (func_type'(req_func) == FN_LOCK);
               cur_in  = first;
               ok_in   = 1'b1;
               fin_in  = (pages == '0) || (first >= limit);
            end
            FN_NONE: begin
               ok_in  = 1'b0;
               fin_in = 1'b1;
            end
            default: begin
               fin_in = 1'b1;
            end
         endcase
      end else if (cmd.fetch) begin
         word_in  = rdv_ff ? rd_ff : {WORD_BITS{1'b1}};
         dirty_in = 1'b0;
      end else if (cmd.step) begin
         if (scan_ff) begin
            if (cur_ff >= limit) begin
               // search ran off the end: miss, no wrap
               hint_in = '0;
               ok_in   = 1'b0;
               fin_in  = 1'b1;
               leave   = 1'b1;
            end else if (run_n == cnt_ff) begin
               // hit: go back and mark the run
               hint_in  = cur_ff + 1'b1;
               start_in = hit_start[PIDX_W-1:0];
               ok_in    = 1'b1;
               scan_in  = 1'b0;
               busy_in  = 1'b1;
               cur_in   = hit_start;
               rem_in   = cnt_ff;
               leave    = 1'b1;
            end else begin
               run_in = run_n;
               cur_in = cur_ff + 1'b1;
               leave  = word_end;
            end
         end else begin
            if ((rem_ff == '0) || (cur_ff >= limit)) begin
               fin_in = 1'b1;
               leave  = 1'b1;
            end else begin
               modify = 1'b1;
               word_in[cur_ff[BIT_W-1:0]] = busy_ff;
               dirty_in = 1'b1;
               cur_in   = cur_ff + 1'b1;
               rem_in   = rem_ff - 1'b1;
               leave    = word_end;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= 13'(MAX_PAGES);
         hint_ff      <= '0;
         valid_ff     <= '0;
         fin_ff       <= 1'b0;
         scan_ff      <= 1'b0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) total_ff <= csr_wr_data;
         hint_ff  <= hint_in;
         fin_ff   <= fin_in;
         scan_ff  <= scan_in;
         dirty_ff <= dirty_in;
         if (cmd.write) valid_ff[widx_ff] <= 1'b1;
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      run_ff   <= run_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      busy_ff  <= busy_in;
      ok_ff    <= ok_in;
      start_ff <= start_in;
      word_ff  <= word_in;
      if (cmd.load) begin
         widx_ff <= cur_ff[BIT_W +: WIDX_W];
         rd_ff   <= mem[cur_ff[BIT_W +: WIDX_W]];
         rdv_ff  <= valid_ff[cur_ff[BIT_W +: WIDX_W]];
      end
      if (cmd.write) mem[widx_ff] <= word_ff;
      if (cmd.respond) begin
         rsp_ok_ff   <= ok_ff;
         rsp_page_ff <= ok_ff ? start_ff : '0;
      end
   end

   assign status.fin      = fin_ff;
   assign status.leave    = leave;
   assign status.dirty    = dirty_ff | modify;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_run_address = ADDR_W'({rsp_page_ff, {PAGE_SHIFT{1'b0}}});

endmodule
`default_nettype wire

@@ rtl/bitmap_page_allocator.sv @@
// bitmap_page_allocator: top level joining controller and datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath.
//
// Next-fit page allocator over a 4096-page occupancy bitmap held in a 64x64
// memory. One request is worked at a time and the walker handles one page per
// cycle while in its walk state, pausing at each word boundary. Each bitmap
// word visited adds a read step and a fetch step, and a write-back step when
// modified; a free, lock or marking pass ends with a walk step that sees its
// count run out, and every request ends with a final pass through the load
// state and a response state. A request that finishes at once (zero size,
// hint or first page at or past the total, unknown code) goes from the load
// state straight to the response state. The result register lets the next
// request be accepted while a result waits. After reset the whole bitmap
// reads occupied with no clearing pass.
`default_nettype none
module bitmap_page_allocator (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [1:0]                   req_func,
   input  wire  [bpa_pkg::ADDR_W-1:0]   req_address,
   input  wire  [bpa_pkg::COUNT_W-1:0]  req_byte_count,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_ok,
   output logic [bpa_pkg::ADDR_W-1:0]   rsp_run_address,
   input  wire                          csr_wr_en,
   input  wire  [12:0]                  csr_wr_data
);
   import bpa_pkg::*;

   cmd_type    cmd;
   status_type status;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bpa_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_address     (req_address),
      .req_byte_count  (req_byte_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_run_address (rsp_run_address),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
`default_nettype wire

@@ rtl/bpa_checker.sv @@
// bpa_checker: port-level assertions for bitmap_page_allocator, bound to the
// top level. Depends on bpa_pkg.
`default_nettype none
module bpa_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire [1:0]                    req_func,
   input wire [bpa_pkg::ADDR_W-1:0]    req_address,
   input wire [bpa_pkg::COUNT_W-1:0]   req_byte_count,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire                          rsp_ok,
   input wire [bpa_pkg::ADDR_W-1:0]    rsp_run_address,
   input wire                          csr_wr_en,
   input wire [12:0]                   csr_wr_data
);
   import bpa_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_run_address))
      else $error("result beat changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_run_address == '0)
      else $error("failed result carries an address");

   a_page_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_address[PAGE_SHIFT-1:0] == '0)
      else $error("run address not page aligned");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
`default_nettype wire

@@ dv/testbench.sv @@
// testbench: self-checking bench for bitmap_page_allocator with its own
// occupancy map, search hint and page total. Depends on bpa_pkg and the rtl.
`timescale 1ns / 1ps
module testbench;
   import bpa_pkg::*;

   localparam int CYCLE_LIMIT = 30_000_000;
   localparam int SETTLE      = 64;

   typedef struct {
      logic        ok;
      logic [23:0] run_address;
   } result_type;

   typedef struct {
      logic [23:0] base;
      int          pages;
   } run_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   func_type    req_func = FN_NONE;
   logic [23:0] req_address = '0;
   logic [24:0] req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_ok;
   logic [23:0] rsp_run_address;
   logic        csr_wr_en = 0;
   logic [12:0] csr_wr_data = '0;

   bitmap_page_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_address(req_address), .req_byte_count(req_byte_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
      .rsp_run_address(rsp_run_address),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // shadow state of the allocator
   bit          page_map [MAX_PAGES];
   int          hint;
   int          page_total;
   result_type  pending_results [$];
   run_type     live_runs [$];
   int          fails = 0;
   int          cycles = 0;
   int          hold_cycles = 0;
   bit          calm = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   int stall_left = 0;
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if (!calm && $urandom_range(0, 9) == 0)
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 60);
      end
   end

   task report_mismatch(input string what, input logic [23:0] got,
                        input logic [23:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
      fails++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat", rsp_run_address, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok)
               report_mismatch("ok", {23'd0, rsp_ok}, {23'd0, want.ok});
            if (rsp_run_address !== want.run_address)
               report_mismatch("run_address", rsp_run_address, want.run_address);
         end
      end
   end

   function automatic int usable_pages();
      return page_total > MAX_PAGES ? MAX_PAGES : page_total;
   endfunction

   function automatic void mark_range(int first, int count, bit busy);
      int limit;
      limit = usable_pages();
      for (int p = first; p < first + count && p < limit; p++)
         page_map[p] = busy;
   endfunction

   // next-fit search and range updates, one request
   function automatic result_type allocator_step(func_type f, logic [23:0] a,
                                                 logic [24:0] n);
      result_type r;
      int count, limit, run;
      count = int'(({1'b0, n} + 26'd4095) >> PAGE_SHIFT);
      limit = usable_pages();
      run = 0;
      r.ok = 0;
      r.run_address = '0;
      case (f)
         FN_ALLOC: begin
            if (count != 0) begin
               for (int i = hint; i < limit; i++) begin
                  run = page_map[i] ? 0 : run + 1;
                  if (run == count) begin
                     mark_range(i + 1 - count, count, 1);
                     hint = i + 1;
                     r.ok = 1;
                     r.run_address = 24'((i + 1 - count) << PAGE_SHIFT);
                     return r;
                  end
               end
            end
            hint = 0;
         end
         FN_FREE, FN_LOCK: begin
            mark_range(int'(a >> PAGE_SHIFT), count, f == FN_LOCK);
            r.ok = 1;
         end
         default: ;
      endcase
      return r;
   endfunction

   task send_req(input func_type f, input logic [23:0] a, input logic [24:0] n);
      int gap;
      result_type r;
      gap = calm ? 0 : (($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
                                                    : $urandom_range(5, 40));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_address <= a;
      req_byte_count <= n;
      do @(posedge clock); while (!req_ready);
      r = allocator_step(f, a, n);
      pending_results.push_back(r);
      if (f == FN_ALLOC && r.ok)
         live_runs.push_back('{r.run_address, int'(({1'b0, n} + 26'd4095) >> 12)});
   endtask

   task drain();
      req_valid <= 0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_page_total(input logic [12:0] v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      page_total = v;
      live_runs.delete();
   endtask

   task test_directed();
      send_req(FN_ALLOC, 24'h0, 25'd1);            // everything occupied after reset
      send_req(FN_ALLOC, 24'h0, 25'd0);            // zero size
      send_req(FN_FREE, 24'h0, 25'd0);             // zero size free
      send_req(FN_NONE, 24'hFFFFFF, 25'h1FFFFFF);
      send_req(FN_FREE, 24'h000123, 25'd8192);     // unaligned address
      send_req(FN_ALLOC, 24'h0, 25'd4096);
      send_req(FN_ALLOC, 24'h0, 25'd1);
      send_req(FN_ALLOC, 24'h0, 25'd4097);         // hint at end of free area
      send_req(FN_FREE, 24'h0, 25'd262144);
      send_req(FN_LOCK, 24'h005FFF, 25'd1);
      send_req(FN_ALLOC, 24'h0, 25'd20480);
      send_req(FN_ALLOC, 24'h0, 25'd4000000);      // run longer than reachable
      send_req(FN_LOCK, 24'hFFFFFF, 25'd16777216);
      send_req(FN_FREE, 24'hFFF000, 25'd4096);
      write_page_total(13'd0);
      send_req(FN_FREE, 24'h0, 25'd16777216);
      send_req(FN_ALLOC, 24'h0, 25'd4096);
      write_page_total(13'd8191);                  // above max pages
      send_req(FN_FREE, 24'h0, 25'd16777216);
      send_req(FN_ALLOC, 24'h0, 25'd16777216);
      send_req(FN_ALLOC, 24'h0, 25'd4096);
      send_req(FN_FREE, 24'h0, 25'h1FFFFFF);
      write_page_total(13'd100);
      send_req(FN_FREE, 24'h03F000, 25'd1048576);  // crosses the page total
      send_req(FN_ALLOC, 24'h0, 25'd409600);
      send_req(FN_ALLOC, 24'h0, 25'd4096);
   endtask

   task test_random(input logic [12:0] total, input int items);
      int r, k, limit, pages;
      run_type victim;
      write_page_total(total);
      limit = usable_pages();
      send_req(FN_FREE, 24'h0, 25'd16777216);      // open the managed area
      for (int i = 0; i < items; i++) begin
         if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 45 && live_runs.size() < 40) begin
            pages = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                               : $urandom_range(9, 64);
            send_req(FN_ALLOC, 24'($urandom),
                     25'(pages * 4096 - $urandom_range(0, 1) * $urandom_range(0, 4095)));
         end else if (r < 75 && live_runs.size() > 0) begin
            k = $urandom_range(0, live_runs.size() - 1);
            victim = live_runs[k];
            live_runs.delete(k);
            send_req(FN_FREE, victim.base | 24'($urandom_range(0, 4095)),
                     25'(victim.pages * 4096));
         end else if (r < 90 && limit > 0) begin
            send_req((r < 85) ? FN_FREE : FN_LOCK,
                     24'($urandom_range(0, limit - 1) * 4096 + $urandom_range(0, 4095)),
                     25'($urandom_range(1, 32 * 4096)));
         end else begin
            send_req(func_type'($urandom_range(0, 3)), 24'($urandom),
                     ($urandom_range(0, 99) < 3) ? 25'($urandom_range(0, 16777216))
                                                 : 25'($urandom_range(0, 1 << 17)));
         end
      end
      calm = 0;
   endtask

   task test_backpressure();
      write_page_total(13'd512);
      send_req(FN_FREE, 24'h0, 25'd16777216);
      drain();
      hold_cycles = 400;
      calm = 1;
      for (int i = 0; i < 20; i++)
         send_req(FN_ALLOC, 24'h0, 25'($urandom_range(1, 3 * 4096)));
      calm = 0;
      drain();                                     // sender pauses until empty
      send_req(FN_FREE, 24'h0, 25'd16777216);
   endtask

   initial begin
      hint = 0;
      page_total = MAX_PAGES;
      foreach (page_map[i]) page_map[i] = 1;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(13'd4096, 250);
      test_random(13'($urandom_range(64, 1024)), 300);
      test_random(13'd1, 120);
      test_random(13'($urandom_range(200, 600)), 300);
      test_backpressure();
      test_random(13'($urandom_range(64, 1024)), 300);
      test_random(13'd8191, 150);
      test_random(13'($urandom_range(64, 300)), 300);
      drain();
      if (fails == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator.sv
rtl/bpa_checker.sv
dv/testbench.sv
